// ===== rtl/oott_pkg.sv =====
// ----------------------------------------------------------------------------
// oott_pkg
// Shared widths, command codes and the update struct for the oldest outstanding
// ticket tracker.
// ----------------------------------------------------------------------------
package oott_pkg;

    // Field widths fixed by the command and result formats.
    localparam int OP_W     = 2;
    localparam int TICKET_W = 9;

    // Command codes.
    localparam logic [OP_W-1:0] OP_ISSUE  = 2'd0;
    localparam logic [OP_W-1:0] OP_RETIRE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // Reset value of the ticket count register.
    localparam logic [TICKET_W-1:0] TICKET_COUNT_RESET = 9'd256;

    // Bitmap update request from the command stage to the ticket map.
    typedef struct packed {
        logic                issue;
        logic                retire;
        logic [TICKET_W-1:0] ticket;
    } map_upd_t;

endpackage

// ===== rtl/oott_if.sv =====
// ----------------------------------------------------------------------------
// oott_if
// Valid/ready channels of the tracker: commands in, query results out.
// ----------------------------------------------------------------------------
interface oott_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [oott_pkg::OP_W-1:0]     op;
    logic [oott_pkg::TICKET_W-1:0] ticket;

    modport source (output valid, output op, output ticket, input ready);
    modport sink   (input valid, input op, input ticket, output ready);
endinterface

interface oott_res_if;
    logic                          valid;
    logic                          ready;
    logic [oott_pkg::TICKET_W-1:0] oldest;
    logic                          empty_res;

    modport source (output valid, output oldest, output empty_res, input ready);
    modport sink   (input valid, input oldest, input empty_res, output ready);
endinterface

// ===== rtl/oott_map.sv =====
// ----------------------------------------------------------------------------
// oott_map
// Outstanding bitmap and next-ticket counter. Issue sets the bit of the
// next ticket when it is within the limit; retire clears the named bit.
// ----------------------------------------------------------------------------
module oott_map #(
    parameter int N = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  oott_pkg::map_upd_t            upd,
    input  logic [oott_pkg::TICKET_W-1:0] ticket_count,
    output logic [N-1:0]                  map
);

    localparam logic [31:0] N_U = 32'(N);

    logic [N-1:0]                  map_reg;
    logic [N-1:0]                  map_next;
    logic [oott_pkg::TICKET_W:0]   next_ticket_reg;
    logic [oott_pkg::TICKET_W:0]   next_ticket_next;
    logic                          issue_ok;
    logic                          retire_ok;
    logic [31:0]                   set_pos;
    logic [31:0]                   clr_pos;

    // The issue limit is the ticket count capped at the map depth.
    assign issue_ok = upd.issue
                   && (next_ticket_reg != '0)
                   && (32'(next_ticket_reg) <= 32'(ticket_count))
                   && (32'(next_ticket_reg) <= N_U);
    assign retire_ok = upd.retire
                    && (upd.ticket != '0)
                    && (32'(upd.ticket) <= N_U);

    assign set_pos = 32'(next_ticket_reg) - 32'd1;
    assign clr_pos = 32'(upd.ticket) - 32'd1;

    // Per-entry decode of the set and clear positions.
    always_comb
    begin
        map_next = map_reg;
        for (int i = 0; i < N; i++)
        begin
            if (issue_ok && (set_pos == 32'(i)))
            begin
                map_next[i] = 1'b1;
            end
            if (retire_ok && (clr_pos == 32'(i)))
            begin
                map_next[i] = 1'b0;
            end
        end
    end

    assign next_ticket_next = issue_ok ? next_ticket_reg + 1'b1 : next_ticket_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg         <= '0;
            next_ticket_reg <= (oott_pkg::TICKET_W+1)'(1);
        end
        else
        begin
            map_reg         <= map_next;
            next_ticket_reg <= next_ticket_next;
        end
    end

    assign map = map_reg;

endmodule

// ===== rtl/oott_first_set.sv =====
// ----------------------------------------------------------------------------
// oott_first_set
// Finds the lowest set bit of the bitmap and returns its ticket number,
// or zero with the empty flag when no bit is set.
// ----------------------------------------------------------------------------
module oott_first_set #(
    parameter int N = 256
) (
    input  logic [N-1:0]                  map,
    output logic [oott_pkg::TICKET_W-1:0] oldest,
    output logic                          empty
);

    localparam int IW = (N > 1) ? $clog2(N) : 1;

    logic [N-1:0]  lowest;
    logic [IW-1:0] idx;

    // Isolate the lowest set bit: x & -x leaves a one-hot vector.
    assign lowest = map & (~map + 1'b1);

    // One-hot to binary: each entry contributes its own index.
    always_comb
    begin
        idx = '0;
        for (int i = 0; i < N; i++)
        begin
            idx = idx | ({IW{lowest[i]}} & IW'(i));
        end
    end

    assign empty  = (map == '0);
    assign oldest = empty ? '0 : oott_pkg::TICKET_W'(32'(idx) + 32'd1);

endmodule

// ===== rtl/oldest_outstanding_ticket_tracker.sv =====
// ----------------------------------------------------------------------------
// oldest_outstanding_ticket_tracker
// Issues tickets in increasing order, retires them in any order and
// answers queries with the lowest ticket still outstanding.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake      Payload
//  cmd       in    valid/ready    op, ticket
//  result    out   valid/ready    oldest, empty_res
//  cfg       in    cfg_write      cfg_data (ticket_count)
//
//  One command per cycle while the command channel is not stalled. A
//  command is registered, then applied to the bitmap in the next cycle; a
//  query is answered from that bitmap by a lowest-set-bit encoder into the
//  result register when it leaves the command register. Reset clears the
//  bitmap, sets the next ticket to one and the ticket count to 256. Only a
//  query waiting on a full result register that is not being taken stalls
//  the command channel.
//
module oldest_outstanding_ticket_tracker #(
    parameter int MAX_TICKETS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    oott_cmd_if.sink                      cmd,
    oott_res_if.source                    result,
    input  logic                          cfg_write,
    input  logic [oott_pkg::TICKET_W-1:0] cfg_data
);

    logic                          s1_valid_reg;
    logic [oott_pkg::OP_W-1:0]     s1_op_reg;
    logic [oott_pkg::TICKET_W-1:0] s1_ticket_reg;
    logic                          s1_fire;
    logic                          s1_query;
    logic                          res_valid_reg;
    logic [oott_pkg::TICKET_W-1:0] res_oldest_reg;
    logic                          res_empty_reg;
    logic                          res_free;
    logic [oott_pkg::TICKET_W-1:0] ticket_count_reg;
    oott_pkg::map_upd_t            upd;
    logic [MAX_TICKETS-1:0]        map;
    logic [oott_pkg::TICKET_W-1:0] enc_oldest;
    logic                          enc_empty;

    // Ticket count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticket_count_reg <= oott_pkg::TICKET_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            ticket_count_reg <= cfg_data;
        end
    end

    // Stage control: only a query needs room in the result register.
    assign res_free   = !res_valid_reg || result.ready;
    assign s1_query   = (s1_op_reg == oott_pkg::OP_QUERY);
    assign s1_fire    = s1_valid_reg && (!s1_query || res_free);
    assign cmd.ready  = !s1_valid_reg || s1_fire;

    // Command register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            s1_op_reg     <= cmd.op;
            s1_ticket_reg <= cmd.ticket;
        end
    end

    // Decode the registered command into a bitmap update.
    always_comb
    begin
        upd.issue  = 1'b0;
        upd.retire = 1'b0;
        upd.ticket = s1_ticket_reg;
        case (s1_op_reg)
            oott_pkg::OP_ISSUE:  upd.issue  = s1_fire;
            oott_pkg::OP_RETIRE: upd.retire = s1_fire;
            default:             ;
        endcase
    end

    oott_map #(
        .N (MAX_TICKETS)
    ) u_map (
        .clk          (clk),
        .rst_n        (rst_n),
        .upd          (upd),
        .ticket_count (ticket_count_reg),
        .map          (map)
    );

    oott_first_set #(
        .N (MAX_TICKETS)
    ) u_first_set (
        .map    (map),
        .oldest (enc_oldest),
        .empty  (enc_empty)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_query)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_query)
        begin
            res_oldest_reg <= enc_oldest;
            res_empty_reg  <= enc_empty;
        end
    end

    assign result.valid     = res_valid_reg;
    assign result.oldest    = res_oldest_reg;
    assign result.empty_res = res_empty_reg;

    // An empty answer always carries ticket zero.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.empty_res |-> result.oldest == '0)
        else $error("empty result with nonzero ticket");

    // A query on an empty bitmap yields an empty result next cycle.
    a_query_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_query && (map == '0) |=> result.valid && result.empty_res)
        else $error("query on empty map did not report empty");

    // The command channel stalls only behind a blocked query.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> s1_valid_reg && s1_query && res_valid_reg && !result.ready)
        else $error("command stall without a blocked query");

endmodule
